// File: src/fnv1a_bloom_filter_top_defines.svh
// Assertion macros for the FNV-1a bloom filter block.
`ifndef FNV1A_BLOOM_FILTER_TOP_DEFINES_SVH
`define FNV1A_BLOOM_FILTER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FBF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FBF_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FBF_ASSERT(label, clk, rst_n, prop, msg)
`define FBF_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: src/fbf_pkg.sv
package fbf_pkg;

    localparam int FILTER_WORDS = 8;
    localparam int WORD_IDX_W   = (FILTER_WORDS > 1) ? $clog2(FILTER_WORDS) : 1;
    localparam logic [WORD_IDX_W-1:0] WORD_MASK = WORD_IDX_W'(FILTER_WORDS - 1);

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;
    localparam logic [31:0] SEED_A    = 32'h5bd1e995;
    localparam logic [31:0] SEED_B    = 32'h9e3779b9;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] LAST_STEP = 2'd2;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t        kind;
        logic [31:0] hash;
    } op_t;

    typedef struct packed {
        logic can_push;
        logic has_op;
    } queue_status_t;

    function automatic logic [31:0] probe_pos(input logic [31:0] hash, input logic [1:0] step);
        logic [31:0] pos;
        case (step)
            2'd0:    pos = hash;
            2'd1:    pos = hash ^ SEED_A;
            default: pos = hash ^ SEED_B;
        endcase
        return pos;
    endfunction

    function automatic logic [WORD_IDX_W-1:0] word_index(input logic [31:0] pos);
        logic [WORD_IDX_W-1:0] raw;
        raw = pos[5 +: WORD_IDX_W];
        return raw & WORD_MASK;
    endfunction

endpackage

// File: src/fbf_front.sv
module fbf_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  key_valid,
    output logic                  key_ready,
    input  logic [1:0]            command,
    input  logic [7:0]            key_byte,
    input  logic                  byte_present,
    input  logic                  key_end,
    input  fbf_pkg::queue_status_t q_status,
    output logic                  push,
    output fbf_pkg::op_t          push_op
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;
    logic [31:0] mixed;
    logic [31:0] folded;
    logic        accept;

    assign key_ready = q_status.can_push;
    assign accept    = key_valid && key_ready;
    assign mixed     = hash_reg ^ {24'd0, key_byte};
    assign folded    = byte_present ? (mixed * fbf_pkg::FNV_PRIME) : hash_reg;

    always_comb
    begin
        hash_next    = hash_reg;
        push         = 1'b0;
        push_op.kind = fbf_pkg::CMD_CLEAR;
        push_op.hash = folded;
        if (accept)
        begin
            case (command)
                fbf_pkg::CMD_CLEAR:
                begin
                    hash_next = fbf_pkg::FNV_BASIS;
                    push      = 1'b1;
                end
                fbf_pkg::CMD_ADD,
                fbf_pkg::CMD_TEST:
                begin
                    push_op.kind = (command == fbf_pkg::CMD_ADD) ? fbf_pkg::CMD_ADD
                                                                 : fbf_pkg::CMD_TEST;
                    if (key_end)
                    begin
                        hash_next = fbf_pkg::FNV_BASIS;
                        push      = 1'b1;
                    end
                    else
                    begin
                        hash_next = folded;
                    end
                end
                default:
                begin
                    hash_next = hash_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_reg <= fbf_pkg::FNV_BASIS;
        end
        else
        begin
            hash_reg <= hash_next;
        end
    end

endmodule

// File: src/fbf_op_queue.sv
`include "fnv1a_bloom_filter_top_defines.svh"

module fbf_op_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  fbf_pkg::op_t           push_op,
    input  logic                   pop,
    output fbf_pkg::op_t           head_op,
    output fbf_pkg::queue_status_t q_status
);

    fbf_pkg::op_t                   entries_reg [fbf_pkg::QUEUE_DEPTH];
    logic [fbf_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [fbf_pkg::QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [fbf_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [fbf_pkg::QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [fbf_pkg::QUEUE_CNT_W-1:0] count_reg;
    logic [fbf_pkg::QUEUE_CNT_W-1:0] count_next;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [fbf_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        fbf_pkg::QUEUE_PTR_W'(fbf_pkg::QUEUE_DEPTH - 1);
    localparam logic [fbf_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        fbf_pkg::QUEUE_CNT_W'(fbf_pkg::QUEUE_DEPTH);

    assign q_status.can_push = (count_reg != CNT_FULL);
    assign q_status.has_op   = (count_reg != '0);
    assign head_op           = entries_reg[rd_ptr_reg];
    assign do_push           = push && q_status.can_push;
    assign do_pop            = pop && q_status.has_op;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_op;
        end
    end

    `FBF_NEVER(a_no_overflow, clk, rst_n, push && !q_status.can_push, "op queue overflow")
    `FBF_NEVER(a_no_underflow, clk, rst_n, pop && !q_status.has_op, "op queue underflow")
    `FBF_NEVER(a_count_range, clk, rst_n, count_reg > CNT_FULL, "op queue count out of range")

endmodule

// File: src/fbf_back.sv
`include "fnv1a_bloom_filter_top_defines.svh"

module fbf_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  fbf_pkg::queue_status_t q_status,
    input  fbf_pkg::op_t           head_op,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic                   maybe_present
);

    logic [31:0]                     words_reg [fbf_pkg::FILTER_WORDS];
    fbf_pkg::op_t                    op_reg;
    logic                            busy_reg;
    logic [1:0]                      step_reg;
    logic                            hit_reg;
    logic                            result_valid_reg;
    logic                            maybe_present_reg;

    logic [31:0]                     pos;
    logic [fbf_pkg::WORD_IDX_W-1:0]  widx;
    logic [31:0]                     bmask;
    logic                            hit_bit;
    logic                            final_step;
    logic                            out_block;
    logic                            advance;
    logic                            done;
    logic                            result_load;

    assign pos        = fbf_pkg::probe_pos(op_reg.hash, step_reg);
    assign widx       = fbf_pkg::word_index(pos);
    assign bmask      = 32'd1 << pos[4:0];
    assign hit_bit    = |(words_reg[widx] & bmask);
    assign final_step = (op_reg.kind == fbf_pkg::CMD_CLEAR) || (step_reg == fbf_pkg::LAST_STEP);
    assign result_load = busy_reg && (op_reg.kind == fbf_pkg::CMD_TEST)
                         && (step_reg == fbf_pkg::LAST_STEP);
    assign out_block  = result_load && result_valid_reg && !result_ready;
    assign advance    = busy_reg && !out_block;
    assign done       = advance && final_step;
    assign pop        = q_status.has_op && (!busy_reg || done);

    assign result_valid  = result_valid_reg;
    assign maybe_present = maybe_present_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            step_reg         <= 2'd0;
            hit_reg          <= 1'b1;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < fbf_pkg::FILTER_WORDS; i++)
            begin
                words_reg[i] <= '0;
            end
        end
        else
        begin
            if (pop)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
                hit_reg  <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance)
            begin
                step_reg <= step_reg + 1'b1;
                hit_reg  <= hit_reg & hit_bit;
            end

            if (advance)
            begin
                case (op_reg.kind)
                    fbf_pkg::CMD_ADD:
                    begin
                        words_reg[widx] <= words_reg[widx] | bmask;
                    end
                    fbf_pkg::CMD_CLEAR:
                    begin
                        for (int i = 0; i < fbf_pkg::FILTER_WORDS; i++)
                        begin
                            words_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (advance && result_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= head_op;
        end
        if (advance && result_load)
        begin
            maybe_present_reg <= hit_reg & hit_bit;
        end
    end

    `FBF_NEVER(a_result_not_dropped, clk, rst_n,
        advance && result_load && result_valid_reg && !result_ready,
        "test result would overwrite a pending result")
    `FBF_NEVER(a_step_range, clk, rst_n, busy_reg && (step_reg > fbf_pkg::LAST_STEP),
        "probe step out of range")
    `FBF_ASSERT(a_clear_one_step, clk, rst_n,
        busy_reg && (op_reg.kind == fbf_pkg::CMD_CLEAR) |-> (step_reg == 2'd0),
        "clear op ran past its single step")

endmodule

// File: src/fnv1a_bloom_filter_top.sv
// Bloom filter over byte-string keys with a 32-bit FNV-1a hash and three probes.
// Key bytes are accepted one per cycle while the op queue has room; the front folds
// each byte into the running hash (one constant multiply) and, on the key's last
// beat or a clear, posts an op into a four-entry queue. The back takes one op at a
// time, applies an add or test op one filter word read-modify per probe and a clear
// by zeroing every word; a test answer sits in an output register until taken. Keys
// of three or more bytes therefore stream at one byte per cycle while answers are
// taken, while runs of shorter keys wait on the single probe per cycle in the back.
// Reset clears the filter at once; a key in progress keeps its hash across stalls.
module fnv1a_bloom_filter_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       key_valid,
    output logic       key_ready,
    input  logic [1:0] command,
    input  logic [7:0] key_byte,
    input  logic       byte_present,
    input  logic       key_end,
    output logic       result_valid,
    input  logic       result_ready,
    output logic       maybe_present
);

    fbf_pkg::queue_status_t q_status;
    fbf_pkg::op_t           push_op;
    fbf_pkg::op_t           head_op;
    logic                   push;
    logic                   pop;

    fbf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .key_valid    (key_valid),
        .key_ready    (key_ready),
        .command      (command),
        .key_byte     (key_byte),
        .byte_present (byte_present),
        .key_end      (key_end),
        .q_status     (q_status),
        .push         (push),
        .push_op      (push_op)
    );

    fbf_op_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_op  (push_op),
        .pop      (pop),
        .head_op  (head_op),
        .q_status (q_status)
    );

    fbf_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_status      (q_status),
        .head_op       (head_op),
        .pop           (pop),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .maybe_present (maybe_present)
    );

endmodule

// File: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIB_KEYS     = 16;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       key_valid;
    logic       key_ready;
    logic [1:0] command;
    logic [7:0] key_byte;
    logic       byte_present;
    logic       key_end;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic       maybe_present;

    fnv1a_bloom_filter_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_valid     (key_valid),
        .key_ready     (key_ready),
        .command       (command),
        .key_byte      (key_byte),
        .byte_present  (byte_present),
        .key_end       (key_end),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .maybe_present (maybe_present)
    );

    // model of the filter
    logic [31:0] key_hash;
    logic [31:0] bloom_words [fbf_pkg::FILTER_WORDS];
    logic        presence_expected [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_request  = 0;
    int hold_taken    = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    int errors     = 0;
    int beats_sent = 0;
    int answers    = 0;
    int hits       = 0;
    int clears     = 0;

    logic [63:0] lib_keys [LIB_KEYS];
    int          lib_len  [LIB_KEYS];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int word_sel(input logic [31:0] pos);
        return int'((pos >> 5) & 32'(fbf_pkg::FILTER_WORDS - 1));
    endfunction

    function automatic logic bit_is_set(input logic [31:0] pos);
        return bloom_words[word_sel(pos)][pos[4:0]];
    endfunction

    task automatic set_bit(input logic [31:0] pos);
        bloom_words[word_sel(pos)][pos[4:0]] = 1'b1;
    endtask

    task automatic predict_bloom(input logic [1:0] cmd, input logic [7:0] b, input logic bp,
                                 input logic ke);
        logic [31:0] h;
        if (cmd == fbf_pkg::CMD_CLEAR)
        begin
            for (int i = 0; i < fbf_pkg::FILTER_WORDS; i++)
                bloom_words[i] = '0;
            key_hash = fbf_pkg::FNV_BASIS;
            clears++;
            return;
        end
        if (cmd == CMD_UNUSED)
            return;
        if (bp)
            key_hash = (key_hash ^ {24'd0, b}) * fbf_pkg::FNV_PRIME;
        if (!ke)
            return;
        h = key_hash;
        key_hash = fbf_pkg::FNV_BASIS;
        if (cmd == fbf_pkg::CMD_ADD)
        begin
            set_bit(h);
            set_bit(h ^ fbf_pkg::SEED_A);
            set_bit(h ^ fbf_pkg::SEED_B);
        end
        else
            presence_expected.push_back(bit_is_set(h) && bit_is_set(h ^ fbf_pkg::SEED_A)
                                        && bit_is_set(h ^ fbf_pkg::SEED_B));
    endtask

    // one input beat, with optional idle gap ahead of it
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] b, input logic bp,
                             input logic ke);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            key_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        key_valid    <= 1'b1;
        command      <= cmd;
        key_byte     <= b;
        byte_present <= bp;
        key_end      <= ke;
        @(posedge clk);
        while (!key_ready)
            @(posedge clk);
        predict_bloom(cmd, b, bp, ke);
        if (cmd != CMD_UNUSED)
            beats_sent++;
    endtask

    // key bytes packed low byte first; noisy keys mix commands and insert dead beats
    task automatic send_key(input logic [63:0] kbits, input int len, input logic [1:0] op,
                            input bit noisy);
        logic [1:0] mid_cmd;
        if (len == 0)
        begin
            send_beat(op, 8'($urandom), 1'b0, 1'b1);
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
            begin
                if ($urandom_range(0, 1))
                    send_beat(CMD_UNUSED, 8'($urandom), 1'($urandom), 1'($urandom));
                else
                    send_beat(op, 8'($urandom), 1'b0, 1'b0);
            end
            mid_cmd = op;
            if (noisy && i < len - 1)
                mid_cmd = $urandom_range(0, 1) ? fbf_pkg::CMD_TEST : fbf_pkg::CMD_ADD;
            send_beat(mid_cmd, kbits[8*i +: 8], 1'b1, (i == len - 1));
        end
    endtask

    task automatic test_directed();
        send_beat(fbf_pkg::CMD_TEST, 8'h00, 1'b0, 1'b1);
        send_beat(fbf_pkg::CMD_ADD, 8'hFF, 1'b0, 1'b1);
        send_beat(fbf_pkg::CMD_TEST, 8'h00, 1'b0, 1'b1);
        send_beat(fbf_pkg::CMD_ADD, 8'h00, 1'b1, 1'b0);
        send_beat(fbf_pkg::CMD_ADD, 8'hFF, 1'b1, 1'b1);
        // key built under add, tested on the last beat
        send_beat(fbf_pkg::CMD_ADD, 8'h00, 1'b1, 1'b0);
        send_beat(fbf_pkg::CMD_TEST, 8'hFF, 1'b1, 1'b1);
        send_beat(fbf_pkg::CMD_TEST, 8'hFF, 1'b1, 1'b0);
        send_beat(fbf_pkg::CMD_TEST, 8'h00, 1'b1, 1'b1);
        // unused command inside a key
        send_beat(fbf_pkg::CMD_TEST, 8'h00, 1'b1, 1'b0);
        send_beat(CMD_UNUSED, 8'h55, 1'b1, 1'b1);
        send_beat(fbf_pkg::CMD_TEST, 8'hFF, 1'b1, 1'b1);
        // beat without a byte inside a key
        send_beat(fbf_pkg::CMD_TEST, 8'h00, 1'b1, 1'b0);
        send_beat(fbf_pkg::CMD_TEST, 8'hAA, 1'b0, 1'b0);
        send_beat(fbf_pkg::CMD_TEST, 8'hFF, 1'b1, 1'b1);
        send_beat(fbf_pkg::CMD_TEST, 8'h12, 1'b1, 1'b0);
        send_beat(fbf_pkg::CMD_ADD, 8'h34, 1'b1, 1'b1);
        send_beat(fbf_pkg::CMD_ADD, 8'h12, 1'b1, 1'b0);
        send_beat(fbf_pkg::CMD_TEST, 8'h34, 1'b1, 1'b1);
        // clear in the middle of a key
        send_beat(fbf_pkg::CMD_ADD, 8'h77, 1'b1, 1'b0);
        send_beat(fbf_pkg::CMD_CLEAR, 8'hFF, 1'b1, 1'b1);
        send_beat(fbf_pkg::CMD_TEST, 8'h00, 1'b0, 1'b1);
        send_beat(fbf_pkg::CMD_TEST, 8'h00, 1'b1, 1'b0);
        send_beat(fbf_pkg::CMD_TEST, 8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_random_keys(input int n_beats);
        int          start;
        int          r;
        int          id;
        int          len;
        logic [63:0] kbits;
        logic [1:0]  op;
        for (int i = 0; i < LIB_KEYS; i++)
        begin
            lib_keys[i] = {$urandom, $urandom};
            lib_len[i]  = $urandom_range(0, 5);
        end
        start = beats_sent;
        while (beats_sent - start < n_beats)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                send_beat(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), 1'($urandom));
            else if (r < 9)
                send_beat(fbf_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom), 1'($urandom));
            else if (r < 60)
            begin
                id = $urandom_range(0, LIB_KEYS - 1);
                op = $urandom_range(0, 1) ? fbf_pkg::CMD_TEST : fbf_pkg::CMD_ADD;
                send_key(lib_keys[id], lib_len[id], op, ($urandom_range(0, 4) == 0));
            end
            else
            begin
                kbits = {$urandom, $urandom};
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
                op    = ($urandom_range(0, 9) < 3) ? fbf_pkg::CMD_ADD : fbf_pkg::CMD_TEST;
                send_key(kbits, len, op, ($urandom_range(0, 4) == 0));
            end
        end
    endtask

    // results held off for a long stretch while short test keys keep coming
    task automatic test_stall_fill();
        logic [7:0] seen [4];
        for (int i = 0; i < 4; i++)
        begin
            seen[i] = 8'($urandom);
            send_beat(fbf_pkg::CMD_ADD, seen[i], 1'b1, 1'b1);
        end
        hold_request++;
        for (int i = 0; i < 40; i++)
        begin
            if ($urandom_range(0, 1))
                send_beat(fbf_pkg::CMD_TEST, seen[$urandom_range(0, 3)], 1'b1, 1'b1);
            else
                send_beat(fbf_pkg::CMD_TEST, 8'($urandom), 1'b1, 1'b1);
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_request != hold_taken)
        begin
            hold_left  = HOLD_CYCLES;
            hold_taken = hold_request;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin : check_answer
        logic want;
        if (rst_n && result_valid && result_ready)
        begin
            if (presence_expected.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected answer maybe_present=%b at %0t", maybe_present, $time);
            end
            else
            begin
                want = presence_expected.pop_front();
                answers++;
                if (maybe_present !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("answer mismatch: expected %b, got %b at %0t",
                                 want, maybe_present, $time);
                end
                else if (want)
                    hits++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (key_valid && key_ready) || (result_valid && result_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat accepted in %0d cycles", STALL_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        key_valid    <= 1'b0;
        command      <= fbf_pkg::CMD_ADD;
        key_byte     <= 8'h00;
        byte_present <= 1'b0;
        key_end      <= 1'b0;
        key_hash = fbf_pkg::FNV_BASIS;
        for (int i = 0; i < fbf_pkg::FILTER_WORDS; i++)
            bloom_words[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_idle_pct = 38;
        recv_idle_pct = 69;
        test_random_keys(500);
        send_idle_pct = 69;
        recv_idle_pct = 38;
        test_random_keys(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_keys(450);
        test_stall_fill();
        key_valid <= 1'b0;

        while (presence_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d key beats sent, %0d clears; %0d test answers checked, %0d present",
                 beats_sent, clears, answers, hits);
        $display("idle mixes 38/69, 69/38 and none, plus one %0d-cycle result stall",
                 HOLD_CYCLES);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
